>>> rtl/core/sle_pkg.sv
// shared types and constants for the sorted list engine
package sle_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OpW         = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 5;
  localparam int unsigned CapacityDef = 16;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_SEARCH = 2'd1;
  localparam logic [OpW-1:0] OP_DELETE = 2'd2;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_MISSING = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;  // register compare flags against the incoming key
    logic ins;  // insert: cells at or past the slot take key or left entry
    logic del;  // delete: cells at or past the match take right entry
  } cell_ctrl_t;

endpackage

>>> rtl/core/sle_cell.sv
// one slot of the sorted row: holds an entry and shifts left or right on command
module sle_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sle_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [sle_pkg::DataW-1:0] cmp_key_i,
  input  logic signed [sle_pkg::DataW-1:0] wr_key_i,
  input  logic [CntW-1:0]                 count_i,
  input  logic                            left_lt_i,
  input  logic signed [sle_pkg::DataW-1:0] left_entry_i,
  input  logic signed [sle_pkg::DataW-1:0] right_entry_i,
  output logic                            lt_o,
  output logic                            eq_o,
  output logic signed [sle_pkg::DataW-1:0] entry_o
);

  logic                             occ;
  logic                             lt_q, lt_d;
  logic                             eq_q, eq_d;
  logic signed [sle_pkg::DataW-1:0] entry_q, entry_d;

  assign occ = CntW'(Idx) < count_i;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.cmp) begin
      lt_d = occ && (entry_q < cmp_key_i);
      eq_d = occ && (entry_q == cmp_key_i);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !lt_q) begin
      // first slot not below the key takes it, the rest move one right
      entry_d = left_lt_i ? wr_key_i : left_entry_i;
    end else if (ctrl_i.del && !lt_q) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign entry_o = entry_q;

endmodule

>>> rtl/core/sorted_list_engine_top.sv
// sorted list engine top: row of compare-and-shift cells with handshake control
//
//  channel | direction | handshake            | words
//  in      | input     | in_valid_i/in_ready_o | op_i, value_i
//  out     | output    | out_valid_o/out_ready_i | status_o, count_o
//
// an item goes in two steps: the accept edge registers compare flags in every
// cell, the apply edge shifts the row and loads the result register.
// the row update waits while the result register still holds an untaken word.
// reset clears the count and control state; entries above the count are never read.
// every operation touches all cells at once, so time per item does not depend
// on capacity.
module sorted_list_engine_top #(
  parameter int unsigned Capacity = sle_pkg::CapacityDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sle_pkg::OpW-1:0]            op_i,
  input  logic signed [sle_pkg::DataW-1:0]   value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sle_pkg::StatusW-1:0]        status_o,
  output logic [sle_pkg::CountW-1:0]         count_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic                             state_q, state_d;
  logic [sle_pkg::OpW-1:0]          op_q;
  logic signed [sle_pkg::DataW-1:0] key_q;
  logic [CntW-1:0]                  count_q, count_d;
  logic                             out_valid_q, out_valid_d;
  logic [sle_pkg::StatusW-1:0]      status_q, status_d;
  logic [sle_pkg::CountW-1:0]       out_count_q;
  logic [CntW+sle_pkg::CountW-1:0]  count_ext;

  logic                             in_fire;
  logic                             apply;
  logic                             full;
  logic                             hit;
  sle_pkg::cell_ctrl_t              ctrl;

  logic [Capacity-1:0]              lt_w;
  logic [Capacity-1:0]              eq_w;
  logic signed [sle_pkg::DataW-1:0] entry_w [Capacity];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign apply      = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);
  assign full       = (count_q == CntW'(Capacity));
  assign hit        = |eq_w;

  assign ctrl.cmp = in_fire;
  assign ctrl.ins = apply && (op_q == sle_pkg::OP_INSERT) && !full;
  assign ctrl.del = apply && (op_q == sle_pkg::OP_DELETE) && hit;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic                             left_lt;
    logic signed [sle_pkg::DataW-1:0] left_entry;
    logic signed [sle_pkg::DataW-1:0] right_entry;

    if (g == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = key_q;
    end else begin : g_mid
      assign left_lt    = lt_w[g-1];
      assign left_entry = entry_w[g-1];
    end

    if (g == Capacity - 1) begin : g_last
      assign right_entry = entry_w[g];
    end else begin : g_inner
      assign right_entry = entry_w[g+1];
    end

    sle_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .cmp_key_i     (value_i),
      .wr_key_i      (key_q),
      .count_i       (count_q),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .lt_o          (lt_w[g]),
      .eq_o          (eq_w[g]),
      .entry_o       (entry_w[g])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = sle_pkg::ST_OK;
    case (op_q)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          status_d = sle_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      sle_pkg::OP_SEARCH: begin
        if (!hit) status_d = sle_pkg::ST_MISSING;
      end
      sle_pkg::OP_DELETE: begin
        if (hit) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = sle_pkg::ST_MISSING;
        end
      end
      default: begin
        status_d = sle_pkg::ST_OK;
      end
    endcase
  end

  assign count_ext = {{sle_pkg::CountW{1'b0}}, count_d};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_APPLY;
      S_APPLY: if (apply) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (apply) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      key_q <= value_i;
    end
    if (apply) begin
      status_q    <= status_d;
      out_count_q <= count_ext[sle_pkg::CountW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("stored count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.del |=> count_q == $past(count_q) - CntW'(1))
    else $error("delete did not shrink the count");

  a_search_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && op_q == sle_pkg::OP_SEARCH) |=> $stable(count_q))
    else $error("search changed the count");

  a_apply_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply |=> out_valid_q && state_q == S_IDLE)
    else $error("apply did not present a result");

endmodule

>>> tb/sorted_list_engine_top_tb.sv
// testbench for the sorted list engine: directed table then random traffic
`timescale 1ns / 100ps

module sorted_list_engine_top_tb;
  import sle_pkg::*;

  localparam int unsigned Capacity = CapacityDef;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int NumRows = 24;
  localparam int NumRandom = 1500;

  typedef struct {
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value;
    int                      reps;
    bit                      typed;
    logic [StatusW-1:0]      status;
    logic [CountW-1:0]       count;
  } stim_row_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } list_reply_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [OpW-1:0]            op_i = OP_INSERT;
  logic signed [DataW-1:0]   value_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [StatusW-1:0]        status_o;
  logic [CountW-1:0]         count_o;

  // contents of the list as the block should hold them, ascending
  logic signed [DataW-1:0] sorted_vals[$];
  list_reply_t             expected_replies[$];

  bit src_idle_on = 1'b0;
  bit sink_stall_on = 1'b0;
  int n_errors = 0;
  int n_words = 0;
  int n_replies = 0;
  int n_full = 0;
  int n_missing = 0;

  // insert before the first value not less than the key; delete the first equal one
  stim_row_t dir_rows [NumRows] = '{
    '{OP_SEARCH, 32'sh0000_0000, 1, 1, ST_MISSING, 5'd0},
    '{OP_DELETE, 32'sh0000_0000, 1, 1, ST_MISSING, 5'd0},
    '{OpUnused,  32'sh0000_0000, 1, 1, ST_OK,      5'd0},
    '{OP_INSERT, 32'sh8000_0000, 1, 1, ST_OK,      5'd1},
    '{OP_INSERT, 32'sh7fff_ffff, 1, 1, ST_OK,      5'd2},
    '{OP_INSERT, 32'sh0000_0000, 1, 1, ST_OK,      5'd3},
    '{OP_INSERT, 32'shffff_ffff, 1, 1, ST_OK,      5'd4},
    '{OP_INSERT, 32'sh0000_0000, 1, 1, ST_OK,      5'd5},
    '{OP_SEARCH, 32'sh8000_0000, 1, 1, ST_OK,      5'd5},
    '{OP_SEARCH, 32'sh7fff_ffff, 1, 1, ST_OK,      5'd5},
    '{OP_SEARCH, 32'sh0000_0001, 1, 1, ST_MISSING, 5'd5},
    '{OP_SEARCH, 32'sh7fff_fffe, 1, 0, ST_OK,      5'd0},
    '{OP_DELETE, 32'sh0000_0000, 1, 1, ST_OK,      5'd4},
    '{OP_SEARCH, 32'sh0000_0000, 1, 1, ST_OK,      5'd4},
    '{OP_DELETE, 32'sh0000_0000, 1, 1, ST_OK,      5'd3},
    '{OP_SEARCH, 32'sh0000_0000, 1, 1, ST_MISSING, 5'd3},
    '{OP_DELETE, 32'sh0000_0005, 1, 1, ST_MISSING, 5'd3},
    '{OpUnused,  32'shffff_ffff, 1, 1, ST_OK,      5'd3},
    '{OP_INSERT, 32'sh0000_0100, 13, 0, ST_OK,     5'd0},
    '{OP_INSERT, 32'sh8000_0000, 1, 1, ST_FULL,    5'd16},
    '{OP_DELETE, 32'sh8000_0000, 1, 1, ST_OK,      5'd15},
    '{OP_INSERT, 32'sh8000_0001, 1, 0, ST_OK,      5'd0},
    '{OP_DELETE, 32'sh7fff_ffff, 1, 1, ST_OK,      5'd15},
    '{OP_DELETE, 32'sh0000_0100, 1, 0, ST_OK,      5'd0}
  };

  logic signed [DataW-1:0] hot_values [8] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
    32'sh0000_0001, 32'sh8000_0001, 32'sh7fff_fffe, 32'sh0000_0100
  };

  sorted_list_engine_top #(
    .Capacity(Capacity)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  always #2 clk_i = ~clk_i;

  // what the list does with one word
  task automatic apply_to_list(input logic [OpW-1:0] op, input logic signed [DataW-1:0] val,
                               output list_reply_t reply);
    int pos;
    bit hit;
    pos = 0;
    reply.status = ST_OK;
    while (pos < sorted_vals.size() && sorted_vals[pos] < val) pos++;
    hit = (pos < sorted_vals.size()) && (sorted_vals[pos] == val);
    case (op)
      OP_INSERT: begin
        if (sorted_vals.size() >= Capacity) reply.status = ST_FULL;
        else sorted_vals.insert(pos, val);
      end
      OP_SEARCH: begin
        if (!hit) reply.status = ST_MISSING;
      end
      OP_DELETE: begin
        if (hit) sorted_vals.delete(pos);
        else reply.status = ST_MISSING;
      end
      default: ;
    endcase
    reply.count = CountW'(sorted_vals.size());
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!src_idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // hold the word until it is taken, then record what should come back
  task automatic send_word(input logic [OpW-1:0] op, input logic signed [DataW-1:0] val,
                           input bit typed, input list_reply_t typed_reply);
    int unsigned gap;
    list_reply_t reply;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    apply_to_list(op, val, reply);
    expected_replies.push_back(typed ? typed_reply : reply);
    n_words++;
  endtask

  initial begin
    list_reply_t typed_reply;
    logic [OpW-1:0] op;
    logic signed [DataW-1:0] val;
    int unsigned r;
    bit filling;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      typed_reply.status = dir_rows[i].status;
      typed_reply.count = dir_rows[i].count;
      repeat (dir_rows[i].reps) send_word(dir_rows[i].op, dir_rows[i].value,
                                          dir_rows[i].typed, typed_reply);
    end

    filling = 1'b0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) begin
        src_idle_on = $urandom_range(0, 2) != 0;
        sink_stall_on = $urandom_range(0, 2) != 0;
      end
      // swing the list between empty and full
      if (n % 64 == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (r < 5) op = OpUnused;
      else if (r < 25) op = OP_SEARCH;
      else if (filling) op = (r < 80) ? OP_INSERT : OP_DELETE;
      else op = (r < 40) ? OP_INSERT : OP_DELETE;
      r = $urandom_range(0, 99);
      if (r < 35) val = hot_values[$urandom_range(0, 7)];
      else if (r < 70 && sorted_vals.size() != 0) begin
        val = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        if (r >= 63) val = val + 1;
      end else val = $urandom;
      typed_reply = '0;
      send_word(op, val, 1'b0, typed_reply);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d words sent, %0d replies checked: %0d not found, %0d dropped when full",
             n_words, n_replies, n_missing, n_full);
    if (n_errors == 0) $display("sorted_list_engine_top_tb: clean");
    else $display("sorted_list_engine_top_tb: errors");
    $finish;
  end

  // sink side: runs of ready, short stalls and the odd long one
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!sink_stall_on || $urandom_range(0, 99) < 60) out_ready_i <= 1'b1;
      else if ($urandom_range(0, 99) < 90) out_ready_i <= 1'b0;
      else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(8, 40)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    list_reply_t exp_reply;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_replies++;
      if (expected_replies.size() == 0) begin
        n_errors++;
        $display("%0t: word with nothing expected, status %0d count %0d",
                 $time, status_o, count_o);
      end else begin
        exp_reply = expected_replies.pop_front();
        if (exp_reply.status == ST_FULL) n_full++;
        if (exp_reply.status == ST_MISSING) n_missing++;
        if (status_o !== exp_reply.status) begin
          n_errors++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_reply.status, status_o);
        end
        if (count_o !== exp_reply.count) begin
          n_errors++;
          $display("%0t: count mismatch, expected %0d actual %0d",
                   $time, exp_reply.count, count_o);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d replies outstanding", $time, expected_replies.size());
    $display("sorted_list_engine_top_tb: errors");
    $finish;
  end

endmodule
